// ----- design/pte_pkg.sv -----
// Shared types and constants for the pulse trigger / echo capture timer.
package pte_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int PRESCALE_WIDTH = 16;
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH  = 1;

    localparam logic [PRESCALE_WIDTH-1:0] PRESCALER_DIV_RESET = PRESCALE_WIDTH'(46);
    localparam logic [COUNT_WIDTH-1:0]    COUNTER_TOP_RESET   = {COUNT_WIDTH{1'b1}};

    localparam logic [CFG_IDX_WIDTH-1:0] REG_PRESCALER_DIV = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COUNTER_TOP   = 1'b1;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_ARM   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] pulse_counts;
        logic        edge_falling;
        logic        echo_level;
    } item_t;

    typedef struct packed {
        logic        trigger_level;
        logic        capture_event;
        logic        capture_flag;
        logic [15:0] captured_count;
        logic [15:0] counter_value;
    } result_t;

endpackage

// ----- design/pulse_trigger_echo_capture_timer.sv -----
// Top level: input register, timer core and result register.
//
// Pulse trigger / echo capture timer. Each input transfer is one timer
// event: a tick (tuser mode 0) advances the prescaler and counter and
// samples the echo level, a pulse command (mode 1) restarts the counter and
// raises the trigger until the counter reaches the pulse length, and an arm
// command (mode 2) selects the capture edge and clears the capture flag;
// mode 3 changes nothing. Every input transfer yields exactly one result
// transfer carrying the state after that item. The block sustains one item
// per clock while the downstream side does not stall: the item is held in
// an input register, the core then updates all timer state and loads the
// result register in the same cycle, so a result passes through the input
// register and the result register before it is presented; the state
// update loop in the core sets that rate. Both registers hand off while the
// downstream side takes the previous result, and hold when it stalls.
// Configuration writes (prescaler_div at index 0, counter_top at index 1)
// are meant to be made while idle.
module pulse_trigger_echo_capture_timer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [pte_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [pte_pkg::CFG_WIDTH-1:0]        cfg_data,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [23:0]                          s_axis_tdata,  // pulse_counts[15:0], edge_falling, echo_level, zero pad
    input  logic [1:0]                           s_axis_tuser,  // mode
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [39:0]                          m_axis_tdata   // trigger_level, capture_event, capture_flag, captured_count[15:0], counter_value[15:0], zero pad
);
    import pte_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;
    logic    step;
    logic    accept;

    // Result register frees up when empty or when its transfer completes.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.mode         <= s_axis_tuser;
            in_item_reg.pulse_counts <= s_axis_tdata[15:0];
            in_item_reg.edge_falling <= s_axis_tdata[16];
            in_item_reg.echo_level   <= s_axis_tdata[17];
        end
    end

    pte_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (in_item_reg),
        .result    (core_res)
    );

    // Hold the result until it is taken.
    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0,
                            out_res_reg.counter_value,
                            out_res_reg.captured_count,
                            out_res_reg.capture_flag,
                            out_res_reg.capture_event,
                            out_res_reg.trigger_level};

    a_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed item produced no result");

    a_event_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.capture_event |-> out_res_reg.capture_flag)
        else $error("capture event without capture flag");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending item dropped while result stalled");

endmodule

// ----- design/pte_core.sv -----
// Timer state and per-item update: prescaler, counter, compare and capture.
module pte_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pte_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [pte_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic                                 step,
    input  pte_pkg::item_t                       item,
    output pte_pkg::result_t                     result
);
    import pte_pkg::*;

    logic [PRESCALE_WIDTH-1:0] div_reg;
    logic [COUNT_WIDTH-1:0]    top_reg;

    logic [PRESCALE_WIDTH-1:0] pre_reg, pre_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [COUNT_WIDTH-1:0]    cmp_reg, cmp_next;
    logic [COUNT_WIDTH-1:0]    cap_reg, cap_next;
    logic                      trig_reg, trig_next;
    logic                      armed_reg, armed_next;
    logic                      fall_sel_reg, fall_sel_next;
    logic                      flag_reg, flag_next;
    logic                      echo_reg, echo_next;
    logic                      event_now;

    logic hit;
    logic [COUNT_WIDTH-1:0] count_adv;
    logic [PRESCALE_WIDTH-1:0] pre_adv;

    // Edge detect on the sampled echo level.
    assign hit = fall_sel_reg ? (echo_reg && !item.echo_level)
                              : (!echo_reg && item.echo_level);

    always_comb
    begin
        if (pre_reg >= div_reg)
        begin
            pre_adv   = '0;
            count_adv = (count_reg >= top_reg) ? '0 : count_reg + COUNT_WIDTH'(1);
        end
        else
        begin
            pre_adv   = pre_reg + PRESCALE_WIDTH'(1);
            count_adv = count_reg;
        end
    end

    always_comb
    begin
        pre_next      = pre_reg;
        count_next    = count_reg;
        cmp_next      = cmp_reg;
        cap_next      = cap_reg;
        trig_next     = trig_reg;
        armed_next    = armed_reg;
        fall_sel_next = fall_sel_reg;
        flag_next     = flag_reg;
        echo_next     = echo_reg;
        event_now     = 1'b0;
        unique case (item.mode)
            MODE_TICK:
            begin
                if (hit)
                begin
                    cap_next  = count_reg;
                    flag_next = 1'b1;
                    event_now = 1'b1;
                end
                echo_next  = item.echo_level;
                pre_next   = pre_adv;
                count_next = count_adv;
                if (armed_reg && count_adv == cmp_reg)
                begin
                    trig_next  = 1'b0;
                    armed_next = 1'b0;
                end
            end
            MODE_PULSE:
            begin
                count_next = '0;
                pre_next   = '0;
                trig_next  = 1'b1;
                cmp_next   = COUNT_WIDTH'(item.pulse_counts);
                armed_next = 1'b1;
            end
            MODE_ARM:
            begin
                fall_sel_next = item.edge_falling;
                flag_next     = 1'b0;
            end
            default:
            begin
                event_now = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.trigger_level  = trig_next;
        result.capture_event  = event_now;
        result.capture_flag   = flag_next;
        result.captured_count = 16'(cap_next);
        result.counter_value  = 16'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= PRESCALER_DIV_RESET;
            top_reg <= COUNTER_TOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESCALER_DIV: div_reg <= PRESCALE_WIDTH'(cfg_data);
                REG_COUNTER_TOP:   top_reg <= COUNT_WIDTH'(cfg_data);
                default:           div_reg <= div_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg      <= '0;
            count_reg    <= '0;
            cmp_reg      <= '0;
            cap_reg      <= '0;
            trig_reg     <= 1'b0;
            armed_reg    <= 1'b0;
            fall_sel_reg <= 1'b0;
            flag_reg     <= 1'b0;
            echo_reg     <= 1'b0;
        end
        else if (step)
        begin
            pre_reg      <= pre_next;
            count_reg    <= count_next;
            cmp_reg      <= cmp_next;
            cap_reg      <= cap_next;
            trig_reg     <= trig_next;
            armed_reg    <= armed_next;
            fall_sel_reg <= fall_sel_next;
            flag_reg     <= flag_next;
            echo_reg     <= echo_next;
        end
    end

    a_pulse_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.mode == MODE_PULSE |=> count_reg == '0 && trig_reg && armed_reg)
        else $error("pulse command did not restart the counter");

    a_trig_fall_armed: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(trig_reg) |-> $past(armed_reg) && !armed_reg)
        else $error("trigger fell without an armed compare");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(count_reg) && $stable(cap_reg))
        else $error("timer state moved without an item");

endmodule
